// ===== hdl/skvt_pkg.sv =====
// Shared constants and types for the sorted key/value table.
package skvt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the broadcast key
    logic upd_en;  // apply the update for the current word
    logic set;     // current word is a set
    logic hit;     // some cell holds the broadcast key
    logic full;    // last cell is occupied
  } cell_ctrl_t;

endpackage

// ===== hdl/skvt_cell.sv =====
// One table slot: holds a key/value pair and shifts up from its lower neighbor.
module skvt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  skvt_pkg::cell_ctrl_t      ctrl,
  input  logic [skvt_pkg::KEY_W-1:0] bcast_key,
  input  logic [skvt_pkg::VAL_W-1:0] bcast_value,
  input  logic                      prev_valid,
  input  logic                      prev_lt,
  input  logic [skvt_pkg::KEY_W-1:0] prev_key,
  input  logic [skvt_pkg::VAL_W-1:0] prev_value,
  output logic                      valid,
  output logic                      lt,
  output logic                      eq,
  output logic [skvt_pkg::KEY_W-1:0] key,
  output logic [skvt_pkg::VAL_W-1:0] value
);
  import skvt_pkg::*;

  logic             valid_r, valid_nxt;
  logic             lt_r, eq_r;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic             do_ins;

  assign do_ins = ctrl.upd_en && ctrl.set && !ctrl.hit && !ctrl.full;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.upd_en && ctrl.set && ctrl.hit && eq_r) begin
      value_nxt = bcast_value;
    end else if (do_ins && !lt_r) begin
      if (prev_lt) begin
        // first slot not below the key: drop the new pair in here
        valid_nxt = 1'b1;
        key_nxt   = bcast_key;
        value_nxt = bcast_value;
      end else begin
        // above the insertion point: move up by one slot
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
        value_nxt = prev_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (ctrl.cmp_en) begin
      lt_r <= valid_r && (key_r < bcast_key);
      eq_r <= valid_r && (key_r == bcast_key);
    end
  end

  assign valid = valid_r;
  assign lt    = lt_r;
  assign eq    = eq_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

// ===== hdl/sorted_key_value_table_core.sv =====
// Top level of the sorted key/value table: sequencer, cell chain and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: action (get or set),
//   key, new_value and default_value. Result channel (out_valid/out_ready)
//   returns one word per input word: found, read_value and status.
//   The table is a chain of CAPACITY cells kept in ascending key order; each
//   cell compares its own key against the broadcast key, and on an insert
//   every cell above the insertion point takes its lower neighbor's pair.
// Timing:
//   A word is accepted in the idle state, its compare flags are latched in
//   the next cycle, and the update plus result capture happen in the update
//   state, where out_valid rises with the capture. A new word is taken only
//   after the last one has left the update state (idle, compare, update).
// Reset:
//   rst_n (synchronous, active low) empties the table and the result
//   register; stored keys and values are not cleared, only their valid bits.
// Stall:
//   While a result waits unread, the next word may still be accepted and
//   compared; its update step holds until the result register frees up.
//   A set of a new key into a full table is refused with status 1.
module sorted_key_value_table_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [31:0]               in_key,
  input  logic signed [31:0]        in_new_value,
  input  logic signed [31:0]        in_default_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic signed [31:0]        out_read_value,
  output logic                      out_status
);
  import skvt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;

  // held copy of the word being processed
  logic             act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] new_val_r;
  logic [VAL_W-1:0] dflt_val_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_status_r;

  logic             in_go, upd_go;
  cell_ctrl_t       ctrl;

  logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec;
  logic [KEY_W-1:0]    cell_key   [CAPACITY];
  logic [VAL_W-1:0]    cell_value [CAPACITY];

  logic             hit, full;
  logic [VAL_W-1:0] hit_value;
  logic             res_found, res_status;
  logic [VAL_W-1:0] res_value;

  assign in_ready = (state_r == ST_IDLE);
  assign in_go    = in_valid && in_ready;
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_go) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the word on acceptance.
  always_ff @(posedge clk) begin
    if (in_go) begin
      act_r      <= in_action;
      key_r      <= in_key;
      new_val_r  <= in_new_value;
      dflt_val_r <= in_default_value;
    end
  end

  // Global flags: hit is a plain OR over the latched equality flags, full is
  // the top cell's valid bit since occupied cells form a prefix.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (cell_value[i] & {VAL_W{eq_vec[i]}});
    end
  end

  assign hit  = |eq_vec;
  assign full = valid_vec[CAPACITY-1];

  assign ctrl.cmp_en = (state_r == ST_CMP);
  assign ctrl.upd_en = upd_go;
  assign ctrl.set    = (act_r == ACT_SET);
  assign ctrl.hit    = hit;
  assign ctrl.full   = full;

  // Cell chain. Cell 0 sees a virtual neighbor that is below every key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             p_valid, p_lt;
    logic [KEY_W-1:0] p_key;
    logic [VAL_W-1:0] p_value;

    if (g == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_lt    = 1'b1;
      assign p_key   = '0;
      assign p_value = '0;
    end else begin : g_rest
      assign p_valid = valid_vec[g-1];
      assign p_lt    = lt_vec[g-1];
      assign p_key   = cell_key[g-1];
      assign p_value = cell_value[g-1];
    end

    skvt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .bcast_key   (key_r),
      .bcast_value (new_val_r),
      .prev_valid  (p_valid),
      .prev_lt     (p_lt),
      .prev_key    (p_key),
      .prev_value  (p_value),
      .valid       (valid_vec[g]),
      .lt          (lt_vec[g]),
      .eq          (eq_vec[g]),
      .key         (cell_key[g]),
      .value       (cell_value[g])
    );
  end

  // Result for the current word.
  always_comb begin
    res_found  = hit;
    res_status = STATUS_DONE;
    if (act_r == ACT_GET) begin
      res_value = hit ? hit_value : dflt_val_r;
    end else if (hit) begin
      res_value = new_val_r;
    end else if (full) begin
      res_value  = '0;
      res_status = STATUS_FULL;
    end else begin
      res_value = new_val_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (upd_go) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_found_r  <= res_found;
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  // Occupied cells always form a contiguous prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not a prefix");

  // Keys are unique, so at most one cell can match.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  // An accepted insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && ctrl.set && !hit && !full) |=>
      ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("insert did not add exactly one entry");

  // Lookups and updates never change the occupancy.
  a_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && !(ctrl.set && !hit && !full)) |=> $stable(valid_vec))
    else $error("occupancy changed without an insert");

  // A refused set never reports a found key.
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FULL) |-> !out_found_r)
    else $error("refused set flagged as found");

endmodule

// ===== sim/sorted_key_value_table_checker.sv =====
// Checker for the sorted key/value table: tracks the table contents and scores every result word.
`timescale 1ns / 1ps

module sorted_key_value_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic [31:0]        in_key,
  input  logic signed [31:0] in_new_value,
  input  logic signed [31:0] in_default_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_found,
  input  logic signed [31:0] out_read_value,
  input  logic               out_status,
  output int unsigned        answers_owed,
  output int unsigned        mismatches
);

  import skvt_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               status;
  } table_answer_t;

  logic [KEY_W-1:0] key_col [CAPACITY];
  logic [VAL_W-1:0] val_col [CAPACITY];
  int unsigned      stored;

  table_answer_t    answers_due [$];
  table_answer_t    want;
  int unsigned      errors;
  int unsigned      words_out;

  // Look up or insert one word against the shadow table, keys compared unsigned.
  function automatic table_answer_t table_access(input logic act, input logic [31:0] key,
                                                 input logic [31:0] nv, input logic [31:0] dv);
    table_answer_t a;
    int unsigned   slot;
    int unsigned   j;
    logic          hit;
    a.found      = 1'b0;
    a.read_value = '0;
    a.status     = STATUS_DONE;
    slot = 0;
    while (slot < stored && key_col[slot] < key) slot++;
    hit = (slot < stored) && (key_col[slot] == key);
    if (act == ACT_GET) begin
      a.found      = hit;
      a.read_value = hit ? val_col[slot] : dv;
    end else if (hit) begin
      val_col[slot] = nv;
      a.found       = 1'b1;
      a.read_value  = nv;
    end else if (stored >= CAPACITY) begin
      a.status = STATUS_FULL;
    end else begin
      for (j = stored; j > slot; j--) begin
        key_col[j] = key_col[j-1];
        val_col[j] = val_col[j-1];
      end
      key_col[slot] = key;
      val_col[slot] = nv;
      stored++;
      a.read_value = nv;
    end
    return a;
  endfunction

  // Score results before queuing new words; a word accepted now cannot answer on this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      stored = 0;
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result word %0d: found=%0b value=%0d status=%0b",
                     words_out, out_found, out_read_value, out_status);
        end else begin
          want = answers_due.pop_front();
          if (out_found !== want.found || out_read_value !== want.read_value ||
              out_status !== want.status) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("mismatch on result word %0d: expected found=%0b value=%0d status=%0b, %s",
                       words_out, want.found, want.read_value, want.status,
                       $sformatf("got found=%0b value=%0d status=%0b",
                                 out_found, out_read_value, out_status));
          end
        end
        words_out++;
      end
      if (in_valid && in_ready)
        answers_due.push_back(table_access(in_action, in_key, in_new_value, in_default_value));
    end
    answers_owed <= answers_due.size();
    mismatches   <= errors;
  end

endmodule

// ===== sim/tb_sorted_key_value_table_core.sv =====
// Testbench top for the sorted key/value table: stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps

module tb_sorted_key_value_table_core;

  import skvt_pkg::*;

  localparam int unsigned RANDOM_WORDS    = 600;
  localparam int unsigned POOL_N          = 96;
  localparam int unsigned HOLD_AT         = 120;   // results taken before the long hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;  // quiet cycles; longest legal one is the hold-off
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic               in_action        = ACT_GET;
  logic [31:0]        in_key           = '0;
  logic signed [31:0] in_new_value     = '0;
  logic signed [31:0] in_default_value = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic               out_found;
  logic signed [31:0] out_read_value;
  logic               out_status;

  int unsigned        answers_owed;
  int unsigned        mismatches;
  int unsigned        results_taken    = 0;

  logic [31:0]        key_pool [POOL_N];

  sorted_key_value_table_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_new_value     (in_new_value),
    .in_default_value (in_default_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_read_value   (out_read_value),
    .out_status       (out_status)
  );

  sorted_key_value_table_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_new_value     (in_new_value),
    .in_default_value (in_default_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .answers_owed     (answers_owed),
    .mismatches       (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, some short gaps, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high on return.
  task automatic send_word(input logic act, input logic [31:0] key,
                           input logic [31:0] nv, input logic [31:0] dv);
    in_valid         <= 1'b1;
    in_action        <= act;
    in_key           <= key;
    in_new_value     <= nv;
    in_default_value <= dv;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for the given gap; a zero gap leaves valid up for the next word.
  task automatic pace(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // Main stimulus: directed corner words on an empty table, then random traffic.
  initial begin : stimulus
    int unsigned i;
    int unsigned gap;
    logic        act;
    logic [31:0] key;

    // Build a key pool larger than the table so it fills and refuses new keys;
    // pair some neighbors (k, k+1) to exercise exact compare.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'hFFFF_FFFE;
    for (i = 6; i < POOL_N; i++)
      key_pool[i] = (i % 8 == 7) ? key_pool[i-1] + 1 : $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Get on an empty table answers the default.
    send_word(ACT_GET, 32'h0000_0000, $urandom(), 32'h7FFF_FFFF);       pace(idle_len());
    send_word(ACT_GET, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000);       pace(idle_len());
    // Insert in the middle, at the front, at the end, then into a gap with a shift.
    send_word(ACT_SET, 32'h8000_0000, 32'h0000_0005, $urandom());       pace(idle_len());
    send_word(ACT_SET, 32'h0000_0000, 32'h8000_0000, $urandom());       pace(idle_len());
    send_word(ACT_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, $urandom());       pace(idle_len());
    send_word(ACT_SET, 32'h4000_0000, 32'hFFFF_FFFF, $urandom());       pace(idle_len());
    // Read every stored key back, plus misses on both sides of a stored one.
    send_word(ACT_GET, 32'h0000_0000, $urandom(), 32'h0000_0001);       pace(idle_len());
    send_word(ACT_GET, 32'hFFFF_FFFF, $urandom(), $urandom());          pace(idle_len());
    send_word(ACT_GET, 32'h4000_0000, $urandom(), $urandom());          pace(idle_len());
    send_word(ACT_GET, 32'h8000_0000, $urandom(), $urandom());          pace(idle_len());
    send_word(ACT_GET, 32'h7FFF_FFFF, $urandom(), 32'hFFFF_FFFF);       pace(idle_len());
    send_word(ACT_GET, 32'h8000_0001, $urandom(), 32'h0000_0000);       pace(idle_len());
    // Overwrite existing keys and insert one new key below the top key, reading each new value back.
    send_word(ACT_SET, 32'h8000_0000, 32'hA5A5_A5A5, $urandom());       pace(idle_len());
    send_word(ACT_GET, 32'h8000_0000, $urandom(), $urandom());          pace(idle_len());
    send_word(ACT_SET, 32'h0000_0000, 32'h0000_0000, $urandom());       pace(idle_len());
    send_word(ACT_GET, 32'h0000_0000, $urandom(), 32'h5A5A_5A5A);       pace(idle_len());
    send_word(ACT_SET, 32'hFFFF_FFFE, 32'h5A5A_5A5A, $urandom());       pace(idle_len());
    send_word(ACT_GET, 32'hFFFF_FFFE, $urandom(), $urandom());          pace(idle_len());

    // Random traffic: sets slightly ahead of gets so the table fills, then
    // full-table overwrites and refusals dominate. Run one stretch back to back.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      act = ($urandom_range(0, 99) < 55) ? ACT_SET : ACT_GET;
      key = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, POOL_N-1)];
      send_word(act, key, $urandom(), $urandom());
      gap = (i >= 200 && i < 320) ? 0 : idle_len();
      pace(gap);
    end
    in_valid <= 1'b0;

    // Let the last word reach the checker, drain, then allow for the pipeline.
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("sorted_key_value_table_core test passed");
    end else begin
      $display("sorted_key_value_table_core test failed");
    end
    $finish;
  end

  // Result sink: random stalls, one long hold-off to back the block up into
  // its input, and one stretch of steady ready.
  initial begin : result_sink
    int unsigned stall;
    logic        held_off;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_taken >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = (results_taken >= 300 && results_taken < 400) ? 0 : idle_len();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_key_value_table_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/skvt_pkg.sv
hdl/skvt_cell.sv
hdl/sorted_key_value_table_core.sv
sim/sorted_key_value_table_checker.sv
sim/tb_sorted_key_value_table_core.sv
